// ===== rtl/ghi_pkg.sv =====
// Shared types and constants of the gyro heading integrator.
// Holds field widths, fixed-point turn constants, sequencer states and
// the control/status structs. No dependencies.
package ghi_pkg;

  // Timer width used for dt; field widths of the channel payloads
  localparam int TIMER_BITS = 16;
  localparam int TS_W       = 16;
  localparam int RAW_W      = 16;
  localparam int RATE_W     = 25;
  localparam int HEAD_W     = 46;
  localparam int SUM_W      = 32;
  localparam int CNT_W      = 16;
  localparam int THR_W      = 23;
  localparam int FRAC_BITS  = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 23;

  // Derived datapath widths
  localparam int NOW_W     = (TIMER_BITS > TS_W) ? TIMER_BITS : TS_W;
  localparam int PROD_W    = RATE_W + TIMER_BITS + 1;
  localparam int ALU_W     = ((PROD_W > HEAD_W) ? PROD_W : HEAD_W) + 2;
  localparam int DIVD_W    = SUM_W + FRAC_BITS;
  localparam int DIV_STEPS = DIVD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Heading scale: one degree is 131e6 * 256 units
  localparam longint DEG_UNITS   = 64'sd131000000 * 64'sd256;
  localparam longint HALF_TURN_L = DEG_UNITS * 64'sd180;
  localparam longint FULL_TURN_L = DEG_UNITS * 64'sd360;
  localparam longint HEAD_MAX_L  = (64'sd1 <<< (HEAD_W - 1)) - 64'sd1;
  localparam longint HEAD_MIN_L  = -(64'sd1 <<< (HEAD_W - 1));

  localparam logic signed [ALU_W-1:0] HALF_TURN     = ALU_W'(HALF_TURN_L);
  localparam logic signed [ALU_W-1:0] NEG_HALF_TURN = ALU_W'(-HALF_TURN_L);
  localparam logic signed [ALU_W-1:0] FULL_TURN     = ALU_W'(FULL_TURN_L);
  localparam logic signed [ALU_W-1:0] HEAD_MAX      = ALU_W'(HEAD_MAX_L);
  localparam logic signed [ALU_W-1:0] HEAD_MIN      = ALU_W'(HEAD_MIN_L);

  // Register reset values
  localparam logic [CNT_W-1:0] CAL_SAMPLES_RST = CNT_W'(1000);
  localparam logic [THR_W-1:0] DEADBAND_RST    = THR_W'(6707);

  // Operation codes of the input item
  localparam logic OP_HEADING   = 1'b0;
  localparam logic OP_CALIBRATE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_SAMPLES,
    REG_DEADBAND
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CAL_ADD,
    S_CAL_ABS,
    S_CAL_DIV,
    S_CAL_SIGN,
    S_HDG_RATE,
    S_HDG_ABS,
    S_HDG_MUL,
    S_HDG_ADD,
    S_HDG_WRAP,
    S_FINISH
  } state_t;

  typedef struct packed {
    state_t state;
    logic   in_ready;
  } ghi_ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic operation;
    logic read_ok;
    logic cal_done;
    logic out_free;
  } ghi_status_t;

endpackage

// ===== rtl/ghi_channels.sv =====
// Valid/ready channel interfaces for gyro samples and heading results.
// Depends on ghi_pkg for the payload widths.
interface ghi_sample_if;
  import ghi_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [TS_W-1:0]          timer_count;
  logic signed [RAW_W-1:0]  gyro_raw;
  logic                     read_ok;

  modport source (output valid, operation, timer_count, gyro_raw, read_ok, input ready);
  modport sink   (input valid, operation, timer_count, gyro_raw, read_ok, output ready);
endinterface

interface ghi_result_if;
  import ghi_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [HEAD_W-1:0] heading;
  logic signed [RATE_W-1:0] corrected_rate;
  logic                     calibrated;

  modport source (output valid, heading, corrected_rate, calibrated, input ready);
  modport sink   (input valid, heading, corrected_rate, calibrated, output ready);
endinterface

// ===== rtl/gyro_heading_integrator.sv =====
// Top level of the gyro heading integrator: registers, datapath and output stage.
// Depends on ghi_pkg, ghi_channels, ghi_addsub and ghi_seq.
//
// Usage:
//   gyro_in carries one gyro Z sample per transaction: operation (0 heading
//   update, 1 calibration), timer_count, gyro_raw and read_ok. heading_out
//   returns exactly one result per sample: heading, corrected_rate and the
//   calibrated flag, all as they stand after that sample.
//   cfg_we/cfg_index/cfg_data write calibration_samples (index 0) and
//   deadband_threshold (index 1); write them only while the block is idle.
//   One item is worked at a time; gyro_in.ready is high only when idle.
//   A good heading sample runs S_HDG_RATE, S_HDG_ABS, S_HDG_MUL, S_HDG_ADD
//   and S_HDG_WRAP, a calibration sample runs S_CAL_ADD and the one that
//   closes a calibration run also S_CAL_ABS, S_CAL_DIV and S_CAL_SIGN; every
//   item, a failed heading read at once, ends in S_FINISH, then goes idle.
//   The single shared adder does the adds, compare-subtracts and negates of
//   these steps; the restoring divide yields one bias quotient bit per cycle.
//   A finished result sits in an output register; the block keeps taking
//   samples while it waits and only holds in its last step when a second
//   result is ready before the first is taken.
//   Reset (rst, synchronous) clears heading, bias, calibration progress and
//   the timer reference, and restores the register defaults.
module gyro_heading_integrator (
  input  logic                               clk,
  input  logic                               rst,
  ghi_sample_if.sink                         gyro_in,
  ghi_result_if.source                       heading_out,
  input  logic                               cfg_we,
  input  logic [ghi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ghi_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ghi_pkg::*;

  ghi_ctrl_t   ctrl;
  ghi_status_t status;

  // Configuration registers
  logic [CNT_W-1:0] cal_samples;
  logic [THR_W-1:0] deadband;

  // Architectural state
  logic [TIMER_BITS-1:0]    prev_timer;
  logic signed [HEAD_W-1:0] heading_acc;
  logic signed [RATE_W-1:0] rate_bias;
  logic signed [SUM_W-1:0]  cal_sum;
  logic [CNT_W-1:0]         cal_count;
  logic signed [RATE_W-1:0] last_rate;
  logic                     bias_valid;

  // Working registers
  logic signed [RAW_W-1:0]  raw_q;
  logic                     ok_q;
  logic [TIMER_BITS-1:0]    dt;
  logic signed [ALU_W-1:0]  work;
  logic signed [PROD_W-1:0] prod;
  logic [CNT_W:0]           rem;
  logic [DIVD_W-1:0]        quo;
  logic                     div_neg;

  // Output register
  logic                     out_valid;
  logic signed [HEAD_W-1:0] out_heading;
  logic signed [RATE_W-1:0] out_rate;
  logic                     out_cal;

  // Shared adder operands
  logic signed [ALU_W-1:0]  alu_a;
  logic signed [ALU_W-1:0]  alu_b;
  logic                     alu_sub;
  logic signed [ALU_W-1:0]  alu_y;

  logic [NOW_W-1:0]         now_ext;
  logic [TIMER_BITS-1:0]    now;
  logic [CNT_W:0]           count_inc;
  logic                     below_deadband;
  logic signed [ALU_W-1:0]  head_sat;
  logic signed [RATE_W-1:0] mul_a;
  logic signed [TIMER_BITS:0] mul_b;

  // Timer value reduced to the dt width
  assign now_ext = NOW_W'(gyro_in.timer_count);
  assign now     = now_ext[TIMER_BITS-1:0];

  // Status toward the sequencer
  assign count_inc       = (CNT_W + 1)'(cal_count) + (CNT_W + 1)'(1);
  assign status.in_fire  = gyro_in.valid && ctrl.in_ready;
  assign status.operation = gyro_in.operation;
  assign status.read_ok  = gyro_in.read_ok;
  assign status.cal_done = (count_inc >= (CNT_W + 1)'(cal_samples));
  assign status.out_free = !out_valid || heading_out.ready;

  ghi_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  ghi_addsub u_addsub (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  // Select adder operands for the current step
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (ctrl.state)
      S_CAL_ADD: begin
        alu_a = ALU_W'(cal_sum);
        alu_b = ok_q ? ALU_W'(raw_q) : '0;
      end
      S_CAL_ABS: begin
        alu_b   = ALU_W'(cal_sum);
        alu_sub = cal_sum[SUM_W-1];
      end
      S_CAL_DIV: begin
        alu_a   = $signed(ALU_W'({rem[CNT_W-1:0], quo[DIVD_W-1]}));
        alu_b   = $signed(ALU_W'(cal_count));
        alu_sub = 1'b1;
      end
      S_CAL_SIGN: begin
        alu_b   = $signed(ALU_W'(quo[RATE_W-1:0]));
        alu_sub = div_neg;
      end
      S_HDG_RATE: begin
        alu_a   = ALU_W'(raw_q) <<< FRAC_BITS;
        alu_b   = ALU_W'(rate_bias);
        alu_sub = 1'b1;
      end
      S_HDG_ABS: begin
        alu_b   = work;
        alu_sub = work[ALU_W-1];
      end
      S_HDG_ADD: begin
        alu_a = ALU_W'(heading_acc);
        alu_b = ALU_W'(prod);
      end
      S_HDG_WRAP: begin
        alu_a = work;
        if (work > HALF_TURN) begin
          alu_b   = FULL_TURN;
          alu_sub = 1'b1;
        end else if (work < NEG_HALF_TURN) begin
          alu_b = FULL_TURN;
        end
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  // Deadband test on the rate magnitude, heading saturation, multiplier inputs
  assign below_deadband = ($unsigned(alu_y) < ALU_W'(deadband));
  assign head_sat = (alu_y > HEAD_MAX) ? HEAD_MAX :
                    (alu_y < HEAD_MIN) ? HEAD_MIN : alu_y;
  assign mul_a = last_rate;
  assign mul_b = $signed({1'b0, dt});

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_samples <= CAL_SAMPLES_RST;
      deadband    <= DEADBAND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAL_SAMPLES: cal_samples <= cfg_data[CNT_W-1:0];
        REG_DEADBAND:    deadband    <= cfg_data[THR_W-1:0];
        default:         cal_samples <= cal_samples;
      endcase
    end
  end

  // Architectural state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_timer  <= '0;
      heading_acc <= '0;
      rate_bias   <= '0;
      cal_sum     <= '0;
      cal_count   <= '0;
      last_rate   <= '0;
      bias_valid  <= 1'b0;
    end else begin
      case (ctrl.state)
        S_IDLE: begin
          if (status.in_fire && gyro_in.operation == OP_HEADING) begin
            prev_timer <= now;
          end
        end
        S_CAL_ADD: begin
          cal_sum   <= alu_y[SUM_W-1:0];
          cal_count <= count_inc[CNT_W-1:0];
        end
        S_CAL_SIGN: begin
          rate_bias  <= alu_y[RATE_W-1:0];
          bias_valid <= 1'b1;
          cal_sum    <= '0;
          cal_count  <= '0;
        end
        S_HDG_ABS: begin
          last_rate <= below_deadband ? '0 : work[RATE_W-1:0];
        end
        S_HDG_WRAP: begin
          heading_acc <= head_sat[HEAD_W-1:0];
        end
        default: begin
          bias_valid <= bias_valid;
        end
      endcase
    end
  end

  // Working registers: capture, divide steps, product
  always_ff @(posedge clk) begin
    case (ctrl.state)
      S_IDLE: begin
        if (status.in_fire) begin
          raw_q <= gyro_in.gyro_raw;
          ok_q  <= gyro_in.read_ok;
          dt    <= now - prev_timer;
        end
      end
      S_CAL_ABS: begin
        quo     <= {alu_y[SUM_W-1:0], {FRAC_BITS{1'b0}}};
        rem     <= '0;
        div_neg <= cal_sum[SUM_W-1];
      end
      S_CAL_DIV: begin
        if (!alu_y[ALU_W-1]) begin
          rem <= alu_y[CNT_W:0];
          quo <= {quo[DIVD_W-2:0], 1'b1};
        end else begin
          rem <= {rem[CNT_W-1:0], quo[DIVD_W-1]};
          quo <= {quo[DIVD_W-2:0], 1'b0};
        end
      end
      S_HDG_RATE: work <= alu_y;
      S_HDG_MUL:  prod <= PROD_W'(mul_a * mul_b);
      S_HDG_ADD:  work <= alu_y;
      default: begin
        work <= work;
      end
    endcase
  end

  // Output register: load on the last step, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.state == S_FINISH && status.out_free) begin
      out_valid <= 1'b1;
    end else if (heading_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.state == S_FINISH && status.out_free) begin
      out_heading <= heading_acc;
      out_rate    <= last_rate;
      out_cal     <= bias_valid;
    end
  end

  assign gyro_in.ready              = ctrl.in_ready;
  assign heading_out.valid          = out_valid;
  assign heading_out.heading        = out_heading;
  assign heading_out.corrected_rate = out_rate;
  assign heading_out.calibrated     = out_cal;

  // Bias, once valid, stays valid until reset
  a_bias_sticky: assert property (@(posedge clk) disable iff (rst)
    bias_valid |=> bias_valid)
    else $error("calibrated flag dropped");

  // A result appears only after the last step of an item
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.state == S_FINISH))
    else $error("result valid without a finished item");

  // An accepted transaction always starts work
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    status.in_fire |=> ctrl.state != S_IDLE)
    else $error("accepted transaction left the sequencer idle");

endmodule

// ===== rtl/ghi_addsub.sv =====
// Shared add/subtract unit of the integrator datapath.
// Depends on ghi_pkg for the datapath width.
module ghi_addsub (
  input  logic signed [ghi_pkg::ALU_W-1:0] a,
  input  logic signed [ghi_pkg::ALU_W-1:0] b,
  input  logic                             sub,
  output logic signed [ghi_pkg::ALU_W-1:0] y
);
  import ghi_pkg::*;

  logic [ALU_W-1:0] b_op;

  // Invert and carry in for subtraction
  assign b_op = sub ? ~b : b;
  assign y    = a + $signed(b_op) + $signed(ALU_W'(sub));

endmodule

// ===== rtl/ghi_seq.sv =====
// Sequencer of the integrator: steps the shared adder through calibration,
// bias division and heading update. Depends on ghi_pkg.
module ghi_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  ghi_pkg::ghi_status_t status,
  output ghi_pkg::ghi_ctrl_t   ctrl
);
  import ghi_pkg::*;

  state_t               state;
  state_t               state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 div_last;

  assign div_last = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));

  // Advance state and division step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CAL_ABS) begin
        div_cnt <= '0;
      end else if (state == S_CAL_DIV) begin
        div_cnt <= div_cnt + 1'b1;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (status.in_fire) begin
          if (status.operation == OP_CALIBRATE) begin
            state_next = S_CAL_ADD;
          end else if (status.read_ok) begin
            state_next = S_HDG_RATE;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_CAL_ADD:  state_next = status.cal_done ? S_CAL_ABS : S_FINISH;
      S_CAL_ABS:  state_next = S_CAL_DIV;
      S_CAL_DIV:  state_next = div_last ? S_CAL_SIGN : S_CAL_DIV;
      S_CAL_SIGN: state_next = S_FINISH;
      S_HDG_RATE: state_next = S_HDG_ABS;
      S_HDG_ABS:  state_next = S_HDG_MUL;
      S_HDG_MUL:  state_next = S_HDG_ADD;
      S_HDG_ADD:  state_next = S_HDG_WRAP;
      S_HDG_WRAP: state_next = S_FINISH;
      S_FINISH:   state_next = status.out_free ? S_IDLE : S_FINISH;
      default:    state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl.state    = state;
    ctrl.in_ready = (state == S_IDLE);
  end

endmodule
